@@ rtl/chlu_pkg.sv @@
// ----------------------------------------------------------------------------
// chlu_pkg
// Shared constants and types for the chained hash lookup-or-insert block.
// ----------------------------------------------------------------------------
`default_nettype none

package chlu_pkg;

  localparam int unsigned DefBuckets  = 64;
  localparam int unsigned DefCapacity = 1024;
  localparam int unsigned DefKeyBits  = 16;
  localparam int unsigned DefSlotBits = $clog2(DefCapacity);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HEAD,
    ST_WALK,
    ST_MISS
  } state_e;

endpackage

`default_nettype wire

@@ rtl/chlu_if.sv @@
// ----------------------------------------------------------------------------
// chlu_if
// Valid/ready channels: key request in, slot result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface chlu_key_if
  import chlu_pkg::*;
#(
  parameter int unsigned KEY_BITS = DefKeyBits
);
  logic                valid;
  logic                ready;
  logic [KEY_BITS-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

interface chlu_res_if
  import chlu_pkg::*;
#(
  parameter int unsigned SLOT_BITS = DefSlotBits
);
  logic                 valid;
  logic                 ready;
  logic [SLOT_BITS-1:0] slot_index;
  logic                 inserted;
  logic                 table_full;

  modport source (output valid, output slot_index, output inserted, output table_full,
                  input ready);
  modport sink   (input valid, input slot_index, input inserted, input table_full,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/chained_hash_lookup_or_insert.sv @@
// ----------------------------------------------------------------------------
// chained_hash_lookup_or_insert
// Finds a key in a chained hash table, or links it into a fresh slot if one is free.
//
//   channel  dir  payload                              accepted when
//   key_i    in   key                                  valid && ready
//   res_o    out  slot_index, inserted, table_full     valid && ready
//
// A request registers key and head pointer; ST_HEAD reads the head slot, ST_WALK
// compares slots down the chain, and on a miss ST_MISS links a new head slot.
// One slot compare per cycle while the walk is not stalled, set by the single read port of the slot memory.
// key_i.ready is high only between requests; a result waiting on res_o stalls
// the walk at its last step. Reset empties all buckets at once, no clear pass.
// ----------------------------------------------------------------------------
`default_nettype none

module chained_hash_lookup_or_insert
  import chlu_pkg::*;
#(
  parameter int unsigned BUCKETS  = DefBuckets,
  parameter int unsigned CAPACITY = DefCapacity,
  parameter int unsigned KEY_BITS = DefKeyBits
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  chlu_key_if.sink    key_i,
  chlu_res_if.source  res_o
);

  localparam int unsigned BktW  = $clog2(BUCKETS);
  localparam int unsigned SlotW = $clog2(CAPACITY);
  localparam int unsigned UsedW = $clog2(CAPACITY + 1);

  state_e state_q, state_d;

  logic [KEY_BITS-1:0] key_q;
  logic [BktW-1:0]     bkt_q;
  logic [BUCKETS-1:0]  head_vld_q;
  logic                hv_q;
  logic [SlotW-1:0]    head_rd_q;
  logic [SlotW-1:0]    cur_q, cur_d;
  logic [KEY_BITS-1:0] key_rd_q;
  logic [SlotW:0]      link_rd_q;
  logic [UsedW-1:0]    used_q, used_d;

  logic [SlotW-1:0]    head_mem [BUCKETS];
  logic [KEY_BITS-1:0] key_mem  [CAPACITY];
  logic [SlotW:0]      link_mem [CAPACITY];

  logic             accept;
  logic [BktW-1:0]  bkt_in;
  logic             slot_rd_en;
  logic [SlotW-1:0] slot_rd_addr;
  logic             wr_en;
  logic             out_free;
  logic             tbl_full;
  logic             res_ld;
  logic [SlotW-1:0] res_slot_d;
  logic             res_ins_d;
  logic             res_full_d;

  logic             out_vld_q;
  logic [SlotW-1:0] out_slot_q;
  logic             out_ins_q;
  logic             out_full_q;

  assign key_i.ready = (state_q == ST_IDLE);
  assign accept      = key_i.valid && key_i.ready;
  assign bkt_in      = BktW'(key_i.key);
  assign out_free    = !out_vld_q || res_o.ready;
  assign tbl_full    = (used_q == UsedW'(CAPACITY));

  always_comb begin
    state_d      = state_q;
    cur_d        = cur_q;
    used_d       = used_q;
    slot_rd_en   = 1'b0;
    slot_rd_addr = cur_q;
    wr_en        = 1'b0;
    res_ld       = 1'b0;
    res_slot_d   = cur_q;
    res_ins_d    = 1'b0;
    res_full_d   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) state_d = ST_HEAD;
      end
      ST_HEAD: begin
        if (hv_q) begin
          cur_d        = head_rd_q;
          slot_rd_en   = 1'b1;
          slot_rd_addr = head_rd_q;
          state_d      = ST_WALK;
        end else begin
          state_d = ST_MISS;
        end
      end
      ST_WALK: begin
        if (key_rd_q == key_q) begin
          if (out_free) begin
            res_ld  = 1'b1;
            state_d = ST_IDLE;
          end
        end else if (link_rd_q[SlotW]) begin
          cur_d        = link_rd_q[SlotW-1:0];
          slot_rd_en   = 1'b1;
          slot_rd_addr = link_rd_q[SlotW-1:0];
        end else begin
          state_d = ST_MISS;
        end
      end
      ST_MISS: begin
        if (out_free) begin
          res_ld  = 1'b1;
          state_d = ST_IDLE;
          if (tbl_full) begin
            res_slot_d = '0;
            res_full_d = 1'b1;
          end else begin
            wr_en      = 1'b1;
            used_d     = used_q + UsedW'(1);
            res_slot_d = used_q[SlotW-1:0];
            res_ins_d  = 1'b1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      used_q     <= '0;
      head_vld_q <= '0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      if (wr_en) head_vld_q[bkt_q] <= 1'b1;
      if (res_ld) out_vld_q <= 1'b1;
      else if (res_o.ready) out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    if (accept) begin
      key_q <= key_i.key;
      bkt_q <= bkt_in;
      hv_q  <= head_vld_q[bkt_in];
    end
    if (res_ld) begin
      out_slot_q <= res_slot_d;
      out_ins_q  <= res_ins_d;
      out_full_q <= res_full_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) head_rd_q <= head_mem[bkt_in];
    if (wr_en) head_mem[bkt_q] <= used_q[SlotW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (slot_rd_en) begin
      key_rd_q  <= key_mem[slot_rd_addr];
      link_rd_q <= link_mem[slot_rd_addr];
    end
    if (wr_en) begin
      key_mem[used_q[SlotW-1:0]]  <= key_q;
      link_mem[used_q[SlotW-1:0]] <= {hv_q, head_rd_q};
    end
  end

  assign res_o.valid      = out_vld_q;
  assign res_o.slot_index = out_slot_q;
  assign res_o.inserted   = out_ins_q;
  assign res_o.table_full = out_full_q;

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    used_q <= UsedW'(CAPACITY))
    else $error("slot count beyond capacity");

  a_flags_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> !(out_ins_q && out_full_q))
    else $error("inserted and table_full both set");

  a_full_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_full_q) |-> (out_slot_q == '0))
    else $error("full result with nonzero slot");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |=> (used_q == $past(used_q) + UsedW'(1)) && out_vld_q && out_ins_q)
    else $error("insert did not advance slot count");

endmodule

`default_nettype wire
